// File: hw/rtl/fbie_pkg.sv
// Shared types, constants and command codes of the framebuffer line and invert engine.
package fbie_pkg;

   // Default screen size in pixels.
   localparam int unsigned FBIE_SCREEN_WIDTH  = 128;
   localparam int unsigned FBIE_SCREEN_HEIGHT = 64;

   // Internal coordinate width: it holds a line's furthest pixel (127 + 255)
   // and the largest screen size (1024).
   localparam int unsigned COORD_W = 11;

   localparam logic [7:0] HI_NIBBLE = 8'hf0;
   localparam logic [7:0] LO_NIBBLE = 8'h0f;

   // Command codes.
   localparam logic [1:0] CMD_HLINE = 2'd0;
   localparam logic [1:0] CMD_VLINE = 2'd1;
   localparam logic [1:0] CMD_INVERT = 2'd2;
   localparam logic [1:0] CMD_READ  = 2'd3;

   typedef struct packed {
      logic [1:0] cmd;
      logic [6:0] x_start;
      logic [5:0] y_start;
      logic [6:0] x_end;
      logic [5:0] y_end;
      logic [7:0] run_length;
   } fbie_req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       clipped;
   } fbie_rsp_type;

   // Finished command handed from the sequencer to the output register.
   typedef struct packed {
      logic         valid;
      fbie_rsp_type data;
   } fbie_fin_type;

endpackage

// File: hw/rtl/fbie_frame_ram.sv
// Framebuffer byte store: one write port and one registered read port.
module fbie_frame_ram #(
   parameter int unsigned DEPTH  = 4096,
   parameter int unsigned ADDR_W = 12
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] store_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/fbie_seq.sv
// Command sequencer: walks pixels one at a time through a shared address and
// read-modify-write unit, and clears the framebuffer after reset.
module fbie_seq #(
   parameter int unsigned SCREEN_WIDTH  = fbie_pkg::FBIE_SCREEN_WIDTH,
   parameter int unsigned SCREEN_HEIGHT = fbie_pkg::FBIE_SCREEN_HEIGHT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  fbie_pkg::fbie_req_type req_data,
   input  logic                  rsp_free,
   output fbie_pkg::fbie_fin_type fin
);
   import fbie_pkg::*;

   localparam int unsigned ROW_BYTES    = (SCREEN_WIDTH + 1) / 2;
   localparam int unsigned STORE_DEPTH  = ROW_BYTES * SCREEN_HEIGHT;
   localparam int unsigned STORE_ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int unsigned PROD_W       = 2 * COORD_W;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_STEP  = 3'd2;
   localparam logic [2:0] ST_FETCH = 3'd3;
   localparam logic [2:0] ST_WRITE = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]              state_ff, state_in;
   logic [1:0]              cmd_ff, cmd_in;
   logic [COORD_W-1:0]      xs_ff, xs_in, xe_ff, xe_in, ye_ff, ye_in;
   logic [COORD_W-1:0]      col_ff, col_in, row_ff, row_in;
   logic [7:0]              remain_ff, remain_in;
   logic                    clip_ff, clip_in;
   logic [7:0]              rdata_ff, rdata_in;
   logic [STORE_ADDR_W-1:0] addr_ff, addr_in;
   logic [STORE_ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   logic                    on_screen;
   logic [PROD_W-1:0]       row_off;
   logic [PROD_W-1:0]       addr_sum;
   logic [7:0]              mask;
   logic [7:0]              mem_rd_data;
   logic [7:0]              mod_data;
   logic                    mem_wr_en;
   logic [STORE_ADDR_W-1:0] mem_wr_addr;
   logic [7:0]              mem_wr_data;
   logic                    mem_rd_en;
   logic                    accept;
   logic                    rect_last;

   // Shared address unit: one constant multiply and one add per pixel.
   assign on_screen = (col_ff < COORD_W'(SCREEN_WIDTH)) && (row_ff < COORD_W'(SCREEN_HEIGHT));
   assign row_off   = PROD_W'(ROW_BYTES) * PROD_W'(row_ff);
   assign addr_sum  = row_off + PROD_W'(col_ff >> 1);
   assign mask      = col_ff[0] ? HI_NIBBLE : LO_NIBBLE;
   assign rect_last = (col_ff == xe_ff) && (row_ff == ye_ff);

   always_comb begin
      if (cmd_ff == CMD_INVERT && (mem_rd_data & mask) != 8'd0) begin
         mod_data = mem_rd_data & ~mask;
      end else begin
         mod_data = mem_rd_data | mask;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      xs_in       = xs_ff;
      xe_in       = xe_ff;
      ye_in       = ye_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      remain_in   = remain_ff;
      clip_in     = clip_ff;
      rdata_in    = rdata_ff;
      addr_in     = addr_ff;
      clr_addr_in = clr_addr_ff;

      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == STORE_ADDR_W'(STORE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd_in    = req_data.cmd;
               xs_in     = COORD_W'(req_data.x_start);
               xe_in     = COORD_W'(req_data.x_end);
               ye_in     = COORD_W'(req_data.y_end);
               col_in    = COORD_W'(req_data.x_start);
               row_in    = COORD_W'(req_data.y_start);
               remain_in = req_data.run_length;
               clip_in   = 1'b0;
               rdata_in  = 8'd0;
               if (req_data.cmd == CMD_INVERT &&
                   (req_data.x_start > req_data.x_end || req_data.y_start > req_data.y_end)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_STEP;
               end
            end
         end
         ST_STEP: begin
            addr_in = addr_sum[STORE_ADDR_W-1:0];
            if ((cmd_ff == CMD_HLINE || cmd_ff == CMD_VLINE) && remain_ff == 8'd0) begin
               state_in = ST_DONE;
            end else if (on_screen) begin
               state_in = ST_FETCH;
            end else begin
               // Off-screen pixel: skip it without touching the store.
               case (cmd_ff)
                  CMD_HLINE: begin
                     clip_in   = 1'b1;
                     col_in    = col_ff + 1'b1;
                     remain_in = remain_ff - 1'b1;
                  end
                  CMD_VLINE: begin
                     clip_in   = 1'b1;
                     row_in    = row_ff + 1'b1;
                     remain_in = remain_ff - 1'b1;
                  end
                  CMD_INVERT: begin
                     if (rect_last) begin
                        state_in = ST_DONE;
                     end else if (col_ff == xe_ff) begin
                        col_in = xs_ff;
                        row_in = row_ff + 1'b1;
                     end else begin
                        col_in = col_ff + 1'b1;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_FETCH: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            state_in = ST_STEP;
            case (cmd_ff)
               CMD_HLINE: begin
                  col_in    = col_ff + 1'b1;
                  remain_in = remain_ff - 1'b1;
               end
               CMD_VLINE: begin
                  row_in    = row_ff + 1'b1;
                  remain_in = remain_ff - 1'b1;
               end
               CMD_INVERT: begin
                  if (rect_last) begin
                     state_in = ST_DONE;
                  end else if (col_ff == xe_ff) begin
                     col_in = xs_ff;
                     row_in = row_ff + 1'b1;
                  end else begin
                     col_in = col_ff + 1'b1;
                  end
               end
               default: begin
                  rdata_in = mem_rd_data;
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         cmd_ff      <= CMD_READ;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         cmd_ff      <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      xs_ff     <= xs_in;
      xe_ff     <= xe_in;
      ye_ff     <= ye_in;
      col_ff    <= col_in;
      row_ff    <= row_in;
      remain_ff <= remain_in;
      clip_ff   <= clip_in;
      rdata_ff  <= rdata_in;
      addr_ff   <= addr_in;
   end

   assign mem_rd_en   = (state_ff == ST_FETCH);
   assign mem_wr_en   = (state_ff == ST_CLEAR) || (state_ff == ST_WRITE && cmd_ff != CMD_READ);
   assign mem_wr_addr = (state_ff == ST_CLEAR) ? clr_addr_ff : addr_ff;
   assign mem_wr_data = (state_ff == ST_CLEAR) ? 8'd0 : mod_data;

   fbie_frame_ram #(
      .DEPTH  (STORE_DEPTH),
      .ADDR_W (STORE_ADDR_W)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (addr_ff),
      .rd_data (mem_rd_data)
   );

   assign fin.valid          = (state_ff == ST_DONE);
   assign fin.data.read_data = rdata_ff;
   assign fin.data.clipped   = clip_ff;

`ifndef SYNTHESIS
   // A read command never modifies the framebuffer.
   a_read_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_CLEAR && cmd_ff == CMD_READ) |-> !mem_wr_en)
      else $error("read command wrote the framebuffer");

   // Every store write outside the clearing pass follows a fetch of the same byte.
   a_write_after_fetch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> $past(state_ff) == ST_FETCH && $stable(addr_ff))
      else $error("write without matching fetch");

   // An accepted command always leaves the idle state.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("accepted command was dropped");

   // Only a read command returns data.
   a_data_only_read: assert property (@(posedge clock) disable iff (reset)
      (fin.valid && cmd_ff != CMD_READ) |-> fin.data.read_data == 8'd0)
      else $error("non-read command returned data");

   // Only a line command reports clipping.
   a_clip_only_line: assert property (@(posedge clock) disable iff (reset)
      (fin.valid && (cmd_ff == CMD_INVERT || cmd_ff == CMD_READ)) |-> !fin.data.clipped)
      else $error("clip flag on a non-line command");
`endif

endmodule

// File: hw/rtl/framebuffer_line_and_invert_engine_unit.sv
// Top level of the framebuffer line and invert engine with its result register.
//
// The block keeps a SCREEN_WIDTH by SCREEN_HEIGHT framebuffer at 4 bits per
// pixel, two pixels to a byte, the odd column in the high nibble. A word on
// the req_ channel is one command: horizontal line, vertical line, rectangle
// invert or byte read. Every command returns exactly one word on the rsp_
// channel, carrying the byte read (zero for drawing commands) and a flag
// set when a line ran partly off the screen.
// After reset the framebuffer is cleared by a pass that writes one byte per
// cycle over all ROW_BYTES * SCREEN_HEIGHT bytes (4096 at the default size);
// req_ready stays low until it ends.
// Commands run one at a time. Each on-screen pixel goes through an address,
// a fetch and a write-back step on the store; an off-screen pixel is only
// addressed and skipped. A read goes through the same steps, and the next word
// is taken only after its result has been handed to the output register. The
// result is held in an output register, so a stalled receiver only holds back
// the end of the following command.
module framebuffer_line_and_invert_engine_unit #(
   parameter int unsigned SCREEN_WIDTH  = fbie_pkg::FBIE_SCREEN_WIDTH,
   parameter int unsigned SCREEN_HEIGHT = fbie_pkg::FBIE_SCREEN_HEIGHT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  fbie_pkg::fbie_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output fbie_pkg::fbie_rsp_type rsp_data
);
   import fbie_pkg::*;

   fbie_fin_type fin;
   logic         rsp_free;
   logic         rsp_valid_ff, rsp_valid_in;
   fbie_rsp_type rsp_data_ff, rsp_data_in;

   // The result register can take a new word when it is empty or being emptied.
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   fbie_seq #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_free  (rsp_free),
      .fin       (fin)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (fin.valid && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = fin.data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: sim/tb_framebuffer_line_and_invert_engine_unit.sv
// Self-checking testbench for the framebuffer line and invert engine, with its own frame model.

// Keeps a private copy of the framebuffer, works out the result word of each accepted
// command and compares the words returned by the block against it in order.
class fb_scoreboard;
   logic [7:0] frame_bytes [(fbie_pkg::FBIE_SCREEN_WIDTH + 1) / 2 * fbie_pkg::FBIE_SCREEN_HEIGHT];
   fbie_pkg::fbie_rsp_type awaited_q[$];
   int unsigned failures;

   function new();
      foreach (frame_bytes[k]) frame_bytes[k] = '0;
      failures = 0;
   endfunction

   function bit on_screen(int unsigned col, int unsigned row);
      return col < fbie_pkg::FBIE_SCREEN_WIDTH && row < fbie_pkg::FBIE_SCREEN_HEIGHT;
   endfunction

   function int unsigned byte_addr(int unsigned col, int unsigned row);
      return (col >> 1) + (fbie_pkg::FBIE_SCREEN_WIDTH + 1) / 2 * row;
   endfunction

   function logic [7:0] nibble_of(int unsigned col);
      return col[0] ? fbie_pkg::HI_NIBBLE : fbie_pkg::LO_NIBBLE;
   endfunction

   // Lights one pixel and reports whether it fell off the screen.
   function bit light_pixel(int unsigned col, int unsigned row);
      if (!on_screen(col, row)) return 1'b1;
      frame_bytes[byte_addr(col, row)] |= nibble_of(col);
      return 1'b0;
   endfunction

   function void note_command(fbie_pkg::fbie_req_type c);
      fbie_pkg::fbie_rsp_type r;
      int unsigned n, col, row, k;
      logic [7:0] m;
      r = '0;
      case (c.cmd)
         fbie_pkg::CMD_HLINE: begin
            for (n = 0; n < c.run_length; n++) r.clipped |= light_pixel(c.x_start + n, c.y_start);
         end
         fbie_pkg::CMD_VLINE: begin
            for (n = 0; n < c.run_length; n++) r.clipped |= light_pixel(c.x_start, c.y_start + n);
         end
         fbie_pkg::CMD_INVERT: begin
            if (c.x_start <= c.x_end && c.y_start <= c.y_end) begin
               for (row = c.y_start; row <= c.y_end; row++) begin
                  for (col = c.x_start; col <= c.x_end; col++) begin
                     if (on_screen(col, row)) begin
                        k = byte_addr(col, row);
                        m = nibble_of(col);
                        if ((frame_bytes[k] & m) != 0) frame_bytes[k] &= ~m;
                        else frame_bytes[k] |= m;
                     end
                  end
               end
            end
         end
         fbie_pkg::CMD_READ: begin
            if (on_screen(c.x_start, c.y_start))
               r.read_data = frame_bytes[byte_addr(c.x_start, c.y_start)];
         end
         default: ;
      endcase
      awaited_q.push_back(r);
   endfunction

   function void check_result(fbie_pkg::fbie_rsp_type got);
      fbie_pkg::fbie_rsp_type want;
      if (awaited_q.size() == 0) begin
         failures++;
         $display("%0t: result word with none awaited, actual read_data %02h clipped %0b",
                  $time, got.read_data, got.clipped);
         return;
      end
      want = awaited_q.pop_front();
      if (got.read_data !== want.read_data) begin
         failures++;
         $display("%0t: read_data mismatch, expected %02h actual %02h",
                  $time, want.read_data, got.read_data);
      end
      if (got.clipped !== want.clipped) begin
         failures++;
         $display("%0t: clipped mismatch, expected %0b actual %0b",
                  $time, want.clipped, got.clipped);
      end
   endfunction

   function int unsigned pending();
      return awaited_q.size();
   endfunction
endclass

module tb_framebuffer_line_and_invert_engine_unit;
   import fbie_pkg::*;

   // Watchdog limit for the whole run, including the clearing pass after reset and the
   // full-screen inverts; it leaves a wide margin over the slowest run of this stimulus
   // for stalls on both sides.
   localparam longint unsigned WATCHDOG_CYCLES = 64'd10_000_000;
   localparam int unsigned RANDOM_COMMANDS = 1600;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   fbie_req_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   fbie_rsp_type rsp_data;

   // When low, neither side inserts idle cycles; the main sequence clears it for a
   // stretch of the random commands so that back-to-back words are seen as well.
   bit           idle_on = 1'b1;
   fb_scoreboard sb;

   framebuffer_line_and_invert_engine_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   // Presents one command word from a falling edge and holds it until the block takes
   // it. Random idle cycles go in front of the word while idling is enabled; valid is
   // only lowered on those idle edges, so a word that follows straight on keeps valid
   // high without a glitch.
   task automatic send_command(input fbie_req_type c);
      @(negedge clock);
      while (idle_on && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_command(c);
   endtask

   function automatic fbie_req_type make_command(logic [1:0] cmd, int unsigned xs,
                                                 int unsigned ys, int unsigned xe,
                                                 int unsigned ye, int unsigned len);
      fbie_req_type c;
      c.cmd        = cmd;
      c.x_start    = 7'(xs);
      c.y_start    = 6'(ys);
      c.x_end      = 7'(xe);
      c.y_end      = 6'(ye);
      c.run_length = 8'(len);
      return c;
   endfunction

   // Random command. Lines are mostly short and rectangles mostly small so that the
   // run stays fast; a few of each are drawn from the whole range, and a share of the
   // rectangles are deliberately empty.
   function automatic fbie_req_type random_command();
      fbie_req_type c;
      int unsigned pick;
      int unsigned grow;
      c = make_command(2'($urandom_range(3)), $urandom_range(127), $urandom_range(63),
                       $urandom_range(127), $urandom_range(63), $urandom_range(255));
      pick = $urandom_range(99);
      case (c.cmd)
         CMD_HLINE, CMD_VLINE: begin
            if (pick < 80) c.run_length = 8'($urandom_range(32));
         end
         CMD_INVERT: begin
            if (pick >= 3 && pick < 13) begin
               // Empty rectangle: one edge pair out of order.
               if (pick[0]) begin
                  c.x_start = 7'($urandom_range(127, 1));
                  c.x_end   = 7'($urandom_range(c.x_start - 1));
               end else begin
                  c.y_start = 6'($urandom_range(63, 1));
                  c.y_end   = 6'($urandom_range(c.y_start - 1));
               end
            end else if (pick >= 13) begin
               grow    = $urandom_range(7);
               c.x_end = (c.x_start + grow > 127) ? 7'd127 : 7'(c.x_start + grow);
               grow    = $urandom_range(7);
               c.y_end = (c.y_start + grow > 63) ? 6'd63 : 6'(c.y_start + grow);
            end
         end
         default: ;
      endcase
      return c;
   endfunction

   // Receiver: ready changes only on falling edges and drops at random while idling is on.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= !(idle_on && $urandom_range(99) < 24);
      end
   end

   // Every result word taken by the receiver is checked against the oldest awaited one.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_data);
   end

   initial begin
      int unsigned n;
      sb        = new();
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed commands. The frame starts clear, so the first reads return zero.
      send_command(make_command(CMD_READ, 0, 0, 0, 0, 0));
      send_command(make_command(CMD_READ, 127, 63, 0, 0, 0));
      // A full-width line on the top row, then both of its end bytes.
      send_command(make_command(CMD_HLINE, 0, 0, 127, 63, 128));
      send_command(make_command(CMD_READ, 0, 0, 0, 0, 0));
      send_command(make_command(CMD_READ, 127, 0, 0, 0, 0));
      // A line that starts on an odd column must pick the nibble by column parity.
      send_command(make_command(CMD_HLINE, 5, 1, 0, 0, 4));
      send_command(make_command(CMD_READ, 4, 1, 0, 0, 0));
      send_command(make_command(CMD_READ, 8, 1, 0, 0, 0));
      // Lines that run off the right and bottom edges, and lines of no length.
      send_command(make_command(CMD_HLINE, 120, 63, 0, 0, 255));
      send_command(make_command(CMD_HLINE, 127, 20, 0, 0, 0));
      send_command(make_command(CMD_VLINE, 127, 0, 0, 0, 64));
      send_command(make_command(CMD_VLINE, 3, 60, 0, 0, 10));
      send_command(make_command(CMD_VLINE, 0, 63, 0, 0, 255));
      send_command(make_command(CMD_VLINE, 64, 10, 0, 0, 0));
      // Whole-screen invert, then reads of lit and dark bytes.
      send_command(make_command(CMD_INVERT, 0, 0, 127, 63, 0));
      send_command(make_command(CMD_READ, 0, 0, 0, 0, 0));
      send_command(make_command(CMD_READ, 64, 32, 0, 0, 0));
      // Empty rectangles in each direction leave the frame untouched.
      send_command(make_command(CMD_INVERT, 10, 0, 5, 63, 0));
      send_command(make_command(CMD_INVERT, 0, 40, 127, 10, 0));
      // A single pixel in the far corner.
      send_command(make_command(CMD_INVERT, 127, 63, 127, 63, 0));
      send_command(make_command(CMD_READ, 127, 63, 0, 0, 0));
      send_command(make_command(CMD_INVERT, 0, 0, 127, 63, 0));
      send_command(make_command(CMD_HLINE, 127, 31, 0, 0, 2));
      send_command(make_command(CMD_READ, 126, 31, 0, 0, 0));

      for (n = 0; n < RANDOM_COMMANDS; n++) begin
         idle_on = !(n >= 500 && n < 800);
         send_command(random_command());
      end
      idle_on = 1'b1;
      @(negedge clock);
      req_valid <= 1'b0;

      // Drain the remaining words, then give the block time to show any stray one.
      while (sb.pending() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #(WATCHDOG_CYCLES * 8);
      $display("Some tests failed");
      $finish;
   end

endmodule

// File: files.f
hw/rtl/fbie_pkg.sv
hw/rtl/fbie_frame_ram.sv
hw/rtl/fbie_seq.sv
hw/rtl/framebuffer_line_and_invert_engine_unit.sv
sim/tb_framebuffer_line_and_invert_engine_unit.sv
